// ===== sv/lljd_pkg.sv =====
// Shared types, constants and codes for the least-loaded job dispatcher.
`default_nettype none

package lljd_pkg;

   localparam int MAX_MACHINES = 64;
   localparam int IDX_W        = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;
   localparam int CNT_W        = $clog2(MAX_MACHINES + 2);
   localparam int JOB_W        = 16;
   localparam int LOAD_W       = 17;
   localparam int MCOUNT_W     = 7;
   localparam int LIMIT_W      = 16;
   localparam int CSR_IDX_W    = 1;
   localparam int CSR_DATA_W   = 16;

   localparam logic [MCOUNT_W-1:0] MCOUNT_RESET = 7'd1;
   localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 16'd600;

   localparam logic [CSR_IDX_W-1:0] CSR_MACHINE_COUNT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOAD_LIMIT    = 1'd1;

   typedef enum logic [1:0] {
      STATUS_OK   = 2'd0,
      STATUS_FEW  = 2'd1,
      STATUS_OVER = 2'd2
   } status_code_type;

   typedef struct packed {
      logic [JOB_W-1:0] job_time;
      logic             first_job;
      logic             last_job;
   } req_type;

   typedef struct packed {
      status_code_type   status;
      logic [LOAD_W-1:0] min_load;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_SCAN_ADD,
      ST_ADD,
      ST_FINISH,
      ST_SCAN_RES,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic accept;
      logic step;
      logic scan_clear;
      logic scan_run;
      logic add;
      logic emit;
   } ctl_cmd_type;

   typedef struct packed {
      logic add_needed;
      logic result_scan_needed;
      logic last_job;
      logic scan_done;
   } ctl_stat_type;

endpackage

`default_nettype wire

// ===== sv/lljd_ctrl.sv =====
// Controller state machine sequencing seed, scan, add and result steps.
`default_nettype none

module lljd_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output      logic                  busy,
   input  wire lljd_pkg::ctl_stat_type stat,
   output      lljd_pkg::ctl_cmd_type  cmd
);

   lljd_pkg::state_type state_ff;
   lljd_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lljd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lljd_pkg::ST_IDLE: begin
            if (start) begin
               state_in = lljd_pkg::ST_DECIDE;
            end
         end
         lljd_pkg::ST_DECIDE: begin
            state_in = stat.add_needed ? lljd_pkg::ST_SCAN_ADD : lljd_pkg::ST_FINISH;
         end
         lljd_pkg::ST_SCAN_ADD: begin
            if (stat.scan_done) begin
               state_in = lljd_pkg::ST_ADD;
            end
         end
         lljd_pkg::ST_ADD: begin
            state_in = lljd_pkg::ST_FINISH;
         end
         lljd_pkg::ST_FINISH: begin
            if (!stat.last_job) begin
               state_in = lljd_pkg::ST_IDLE;
            end else if (stat.result_scan_needed) begin
               state_in = lljd_pkg::ST_SCAN_RES;
            end else begin
               state_in = lljd_pkg::ST_EMIT;
            end
         end
         lljd_pkg::ST_SCAN_RES: begin
            if (stat.scan_done) begin
               state_in = lljd_pkg::ST_EMIT;
            end
         end
         lljd_pkg::ST_EMIT: begin
            state_in = lljd_pkg::ST_IDLE;
         end
         default: begin
            state_in = lljd_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         lljd_pkg::ST_IDLE: begin
            busy       = 1'b0;
            cmd.accept = start;
         end
         lljd_pkg::ST_DECIDE: begin
            cmd.step       = 1'b1;
            cmd.scan_clear = 1'b1;
         end
         lljd_pkg::ST_SCAN_ADD: begin
            cmd.scan_run = 1'b1;
         end
         lljd_pkg::ST_ADD: begin
            cmd.add = 1'b1;
         end
         lljd_pkg::ST_FINISH: begin
            cmd.scan_clear = 1'b1;
         end
         lljd_pkg::ST_SCAN_RES: begin
            cmd.scan_run = 1'b1;
         end
         lljd_pkg::ST_EMIT: begin
            cmd.emit = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   a_accept_decides: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == lljd_pkg::ST_DECIDE))
      else $error("accepted word did not enter decide");

   a_emit_returns: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lljd_pkg::ST_EMIT) |=> (state_ff == lljd_pkg::ST_IDLE))
      else $error("controller did not return to idle after emit");

   a_one_command: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.accept, cmd.step, cmd.scan_run, cmd.add, cmd.emit}))
      else $error("more than one datapath command at once");

endmodule

`default_nettype wire

// ===== sv/lljd_dpath.sv =====
// Datapath: settings, load memory, scan-for-minimum unit, adder and result register.
`default_nettype none

module lljd_dpath (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire lljd_pkg::req_type                       req_data,
   input  wire logic                                    csr_we,
   input  wire logic [lljd_pkg::CSR_IDX_W-1:0]          csr_index,
   input  wire logic [lljd_pkg::CSR_DATA_W-1:0]         csr_wdata,
   input  wire lljd_pkg::ctl_cmd_type                   cmd,
   output      lljd_pkg::ctl_stat_type                  stat,
   output      logic                                    rsp_strobe,
   output      lljd_pkg::rsp_type                       rsp_data
);

   localparam logic [lljd_pkg::CNT_W-1:0] JOBS_SAT =
      lljd_pkg::CNT_W'(lljd_pkg::MAX_MACHINES + 1);
   localparam logic [lljd_pkg::CNT_W-1:0] MAX_CNT =
      lljd_pkg::CNT_W'(lljd_pkg::MAX_MACHINES);

   // settings
   logic [lljd_pkg::MCOUNT_W-1:0] mcount_ff, mcount_in;
   logic [lljd_pkg::LIMIT_W-1:0]  limit_ff, limit_in;

   // set state
   logic [lljd_pkg::CNT_W-1:0] jobs_seen_ff, jobs_seen_in;
   logic                       failed_ff, failed_in;
   logic                       last_ff, last_in;

   // current item
   logic [lljd_pkg::JOB_W-1:0] job_ff, job_in;
   logic [lljd_pkg::CNT_W-1:0] cnt_ff, cnt_in;

   // scan unit
   logic [lljd_pkg::CNT_W-1:0]  scan_ptr_ff, scan_ptr_in;
   logic                        rd_vld_ff, rd_vld_in;
   logic                        have_best_ff, have_best_in;
   logic [lljd_pkg::IDX_W-1:0]  rd_idx_ff;
   logic [lljd_pkg::LOAD_W-1:0] rd_data_ff;
   logic [lljd_pkg::LOAD_W-1:0] best_ff, best_in;
   logic [lljd_pkg::IDX_W-1:0]  best_idx_ff, best_idx_in;
   logic                        scan_issue;

   // memory
   logic [lljd_pkg::LOAD_W-1:0] load_mem [lljd_pkg::MAX_MACHINES];
   logic                        wr_en;
   logic [lljd_pkg::IDX_W-1:0]  wr_addr;
   logic [lljd_pkg::LOAD_W-1:0] wr_data;

   // adder and result
   logic [lljd_pkg::LOAD_W-1:0] sum;
   logic                        over;
   logic                        rsp_strobe_ff, rsp_strobe_in;
   lljd_pkg::rsp_type           rsp_data_ff, rsp_data_in;

   assign sum  = lljd_pkg::LOAD_W'(best_ff + {1'b0, job_ff});
   assign over = sum > {1'b0, limit_ff};

   always_comb begin
      mcount_in = mcount_ff;
      limit_in  = limit_ff;
      if (csr_we) begin
         case (csr_index)
            lljd_pkg::CSR_MACHINE_COUNT: mcount_in = csr_wdata[lljd_pkg::MCOUNT_W-1:0];
            lljd_pkg::CSR_LOAD_LIMIT:    limit_in  = csr_wdata[lljd_pkg::LIMIT_W-1:0];
            default: begin
               mcount_in = mcount_ff;
            end
         endcase
      end
   end

   // clamp the machine count into 1..MAX_MACHINES
   always_comb begin
      if (mcount_ff == '0) begin
         cnt_in = lljd_pkg::CNT_W'(1);
      end else if (32'(mcount_ff) > 32'(lljd_pkg::MAX_MACHINES)) begin
         cnt_in = MAX_CNT;
      end else begin
         cnt_in = lljd_pkg::CNT_W'(mcount_ff);
      end
   end

   always_comb begin
      job_in       = job_ff;
      last_in      = last_ff;
      jobs_seen_in = jobs_seen_ff;
      failed_in    = failed_ff;
      if (cmd.accept) begin
         job_in  = req_data.job_time;
         last_in = req_data.last_job;
         if (req_data.first_job) begin
            jobs_seen_in = '0;
            failed_in    = 1'b0;
         end
      end
      if (cmd.step && (jobs_seen_ff != JOBS_SAT)) begin
         jobs_seen_in = jobs_seen_ff + 1'b1;
      end
      if (cmd.add && !failed_ff && over) begin
         failed_in = 1'b1;
      end
      if (cmd.emit) begin
         jobs_seen_in = '0;
         failed_in    = 1'b0;
      end
   end

   // seed the next machine, zero a machine that the current count skips, or write back a sum
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = jobs_seen_ff[lljd_pkg::IDX_W-1:0];
      wr_data = '0;
      if (cmd.step && !failed_ff && (jobs_seen_ff < MAX_CNT)) begin
         wr_en   = 1'b1;
         wr_data = (jobs_seen_ff < cnt_ff) ? {1'b0, job_ff} : '0;
      end else if (cmd.add && !failed_ff && !over) begin
         wr_en   = 1'b1;
         wr_addr = best_idx_ff;
         wr_data = sum;
      end
   end

   assign scan_issue = cmd.scan_run && (scan_ptr_ff < cnt_ff);

   always_comb begin
      scan_ptr_in  = scan_ptr_ff;
      rd_vld_in    = scan_issue;
      have_best_in = have_best_ff;
      best_in      = best_ff;
      best_idx_in  = best_idx_ff;
      if (cmd.scan_clear) begin
         scan_ptr_in  = '0;
         have_best_in = 1'b0;
      end else if (scan_issue) begin
         scan_ptr_in = scan_ptr_ff + 1'b1;
      end
      // strict compare keeps the lowest index on ties
      if (rd_vld_ff && (!have_best_ff || (rd_data_ff < best_ff))) begin
         have_best_in = 1'b1;
         best_in      = rd_data_ff;
         best_idx_in  = rd_idx_ff;
      end
   end

   always_comb begin
      rsp_strobe_in = cmd.emit;
      rsp_data_in   = rsp_data_ff;
      if (cmd.emit) begin
         if (jobs_seen_ff < cnt_ff) begin
            rsp_data_in.status   = lljd_pkg::STATUS_FEW;
            rsp_data_in.min_load = '0;
         end else if (failed_ff) begin
            rsp_data_in.status   = lljd_pkg::STATUS_OVER;
            rsp_data_in.min_load = '0;
         end else begin
            rsp_data_in.status   = lljd_pkg::STATUS_OK;
            rsp_data_in.min_load = best_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mcount_ff     <= lljd_pkg::MCOUNT_RESET;
         limit_ff      <= lljd_pkg::LIMIT_RESET;
         jobs_seen_ff  <= '0;
         failed_ff     <= 1'b0;
         last_ff       <= 1'b0;
         scan_ptr_ff   <= '0;
         rd_vld_ff     <= 1'b0;
         have_best_ff  <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         mcount_ff     <= mcount_in;
         limit_ff      <= limit_in;
         jobs_seen_ff  <= jobs_seen_in;
         failed_ff     <= failed_in;
         last_ff       <= last_in;
         scan_ptr_ff   <= scan_ptr_in;
         rd_vld_ff     <= rd_vld_in;
         have_best_ff  <= have_best_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      best_ff     <= best_in;
      best_idx_ff <= best_idx_in;
      rsp_data_ff <= rsp_data_in;
      rd_idx_ff   <= scan_ptr_ff[lljd_pkg::IDX_W-1:0];
      if (cmd.accept) begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         load_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= load_mem[scan_ptr_ff[lljd_pkg::IDX_W-1:0]];
   end

   assign stat.add_needed         = !failed_ff && (jobs_seen_ff >= cnt_ff);
   assign stat.result_scan_needed = !failed_ff && (jobs_seen_ff >= cnt_ff);
   assign stat.last_job           = last_ff;
   assign stat.scan_done          = (scan_ptr_ff == cnt_ff) && !rd_vld_ff;

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |=> !rsp_strobe_ff)
      else $error("result strobe held for two cycles");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && (rsp_data_ff.status != lljd_pkg::STATUS_OK))
         |-> (rsp_data_ff.min_load == '0))
      else $error("failed result carries a nonzero load");

   a_jobs_sat: assert property (@(posedge clock) disable iff (reset)
      jobs_seen_ff <= JOBS_SAT)
      else $error("job counter passed its saturation value");

   a_add_after_scan: assert property (@(posedge clock) disable iff (reset)
      cmd.add |-> have_best_ff)
      else $error("add issued without a scanned minimum");

endmodule

`default_nettype wire

// ===== sv/least_loaded_job_dispatch.sv =====
// Top level of the least-loaded job dispatcher: controller plus datapath.
//
//   channel   ports                                  direction  handshake
//   request   start, busy, req_data                  in         start & !busy
//   result    rsp_strobe, rsp_data                   out        one-cycle strobe
//   settings  csr_we, csr_index, csr_wdata           in         csr_we
//
// A seeding job keeps busy high through the decide and finish steps. A job that
// goes to the least-loaded machine runs a linear scan over the load memory, one
// read per cycle from its single read port, then the add and write-back. A last
// job adds the final minimum scan and the emit step, or the emit step alone when
// no scan is needed; its word is on the result ports in the cycle busy falls.
// Reset is synchronous and resets settings and control state only. The receiver
// takes every result word in its strobe cycle.
`default_nettype none

module least_loaded_job_dispatch (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output      logic                            busy,
   input  wire lljd_pkg::req_type               req_data,
   input  wire logic                            csr_we,
   input  wire logic [lljd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [lljd_pkg::CSR_DATA_W-1:0] csr_wdata,
   output      logic                            rsp_strobe,
   output      lljd_pkg::rsp_type               rsp_data
);

   lljd_pkg::ctl_cmd_type  cmd;
   lljd_pkg::ctl_stat_type stat;

   lljd_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   lljd_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire
